[sv/bf_tape_machine_executor_assert.svh]
// Assertion macros used by the tape machine executor RTL.
`ifndef BF_TAPE_MACHINE_EXECUTOR_ASSERT_SVH
`define BF_TAPE_MACHINE_EXECUTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bte_pkg.sv]
// Shared constants, types and codes of the tape machine executor.
package bte_pkg;

  localparam int CELL_BITS  = 8;
  localparam int TAPE_DEPTH = 32768;   // power of two: pointer wraps by truncation
  localparam int PC_BITS    = 16;
  localparam int DP_BITS    = $clog2(TAPE_DEPTH);

  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [DP_BITS-1:0]   dp_t;
  typedef logic [PC_BITS-1:0]   pc_t;

  typedef enum logic [3:0] {
    OP_RIGHT   = 4'd0,
    OP_LEFT    = 4'd1,
    OP_ADD     = 4'd2,
    OP_SUB     = 4'd3,
    OP_JZ      = 4'd4,
    OP_JNZ     = 4'd5,
    OP_CLEAR   = 4'd6,
    OP_MODEON  = 4'd7,
    OP_MODEOFF = 4'd8,
    OP_PUTCHAR = 4'd9,
    OP_GETCHAR = 4'd10,
    OP_PUTNUM  = 4'd11,
    OP_GETNUM  = 4'd12
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_NUM  = 2'd2,
    KIND_RUN  = 2'd3
  } kind_t;

  // Instruction held in the execute stage, with the pointer and mode it sees.
  typedef struct packed {
    opcode_t     op;
    logic [15:0] operand;
    logic [15:0] pc;
    logic [7:0]  in_value;
    dp_t         dp;
    logic        mode;
  } exe_item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    kind_t       kind;
    logic [7:0]  value;
    logic [15:0] repeat_cnt;
    logic        to_cmd;
    logic [15:0] read_count;
  } exe_result_t;

  typedef struct packed {
    logic  we;
    cell_t data;
  } tape_wr_t;

endpackage

[sv/bf_tape_machine_executor.sv]
// Top level of the tape machine executor: fetch, tape RAM, execute and output stages.
//
// Usage:
//  - Input channel in_*: one compiled instruction per transfer (opcode, operand,
//    its own pc and the last input value). Output channel out_*: exactly one
//    result per instruction, in order (next pc, output kind and value, repeat
//    count, command-line routing, input values consumed).
//  - A result passes the execute-stage register and then the output register
//    before out_tvalid rises. Throughput is one instruction per cycle while the
//    output is not stalled, one tape read-modify-write each.
//  - Pointer and mode are updated as the instruction is taken. The cell is read
//    in that cycle and written back from the execute stage; a write landing on
//    the address being read in the same cycle is forwarded, so back-to-back
//    instructions on one cell see each other's values.
//  - Reset: pointer and mode clear at once, then a clearing pass writes zero to
//    every tape cell, one per cycle, all 32768 (TAPE_DEPTH) of them. in_tready
//    stays low until it is done.
//  - Receiver stall: the output register holds its result; one more instruction
//    may sit in the execute stage, after which in_tready drops until out_tready
//    returns. Nothing is lost or repeated.
module bf_tape_machine_executor (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[3:0], operand[19:4], pc[35:20],
                                  // in_value[43:36], zero pad[47:44]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // next_pc[15:0], out_value[23:16],
                                  // out_repeat[39:24], read_count[55:40]
  output logic [2:0]  out_tuser   // out_kind[1:0], to_command_line[2]
);

  `include "bf_tape_machine_executor_assert.svh"

  // architectural state held in flops
  bte_pkg::dp_t   dp_r, dp_nxt;
  logic           mode_r, mode_nxt;

  // clearing pass
  logic           clr_busy_r;
  bte_pkg::dp_t   clr_addr_r;

  // execute stage
  logic                 exe_valid_r;
  bte_pkg::exe_item_t   exe_r, exe_nxt;
  logic                 fwd_hit_r, fwd_hit_nxt;
  bte_pkg::cell_t       fwd_data_r;
  bte_pkg::cell_t       cell_val;
  bte_pkg::cell_t       ram_rdata;
  bte_pkg::exe_result_t exe_res;
  bte_pkg::tape_wr_t    exe_wr;

  // output register
  logic                 out_valid_r;
  bte_pkg::exe_result_t out_r;

  logic           in_xfer;
  logic           exe_adv;
  logic           exe_wr_en;
  logic           ram_we;
  bte_pkg::dp_t   ram_waddr;
  bte_pkg::cell_t ram_wdata;

  logic [15:0]    in_operand;

  // handshake
  assign exe_adv   = !out_valid_r || out_tready;
  assign in_tready = !clr_busy_r && (!exe_valid_r || exe_adv);
  assign in_xfer   = in_tvalid && in_tready;

  assign in_operand = in_tdata[19:4];

  // pointer and mode follow the instruction as it is taken
  always_comb begin
    dp_nxt   = dp_r;
    mode_nxt = mode_r;
    if (in_xfer) begin
      unique case (bte_pkg::opcode_t'(in_tdata[3:0]))
        bte_pkg::OP_RIGHT:   dp_nxt = bte_pkg::dp_t'(dp_r + bte_pkg::dp_t'(in_operand));
        bte_pkg::OP_LEFT:    dp_nxt = bte_pkg::dp_t'(dp_r - bte_pkg::dp_t'(in_operand));
        bte_pkg::OP_MODEON:  mode_nxt = 1'b1;
        bte_pkg::OP_MODEOFF: mode_nxt = 1'b0;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    exe_nxt.op       = bte_pkg::opcode_t'(in_tdata[3:0]);
    exe_nxt.operand  = in_operand;
    exe_nxt.pc       = in_tdata[35:20];
    exe_nxt.in_value = in_tdata[43:36];
    exe_nxt.dp       = dp_r;
    exe_nxt.mode     = mode_r;
  end

  // write-back from execute stage collides with the new read: forward it
  assign exe_wr_en   = exe_valid_r && exe_adv && exe_wr.we;
  assign fwd_hit_nxt = exe_wr_en && (exe_r.dp == dp_r);

  // tape RAM port muxing: clearing pass owns the write port after reset
  assign ram_we    = clr_busy_r || exe_wr_en;
  assign ram_waddr = clr_busy_r ? clr_addr_r : exe_r.dp;
  assign ram_wdata = clr_busy_r ? '0 : exe_wr.data;

  bte_ram #(
    .WIDTH (bte_pkg::CELL_BITS),
    .DEPTH (bte_pkg::TAPE_DEPTH)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_xfer),
    .raddr (dp_r),
    .rdata (ram_rdata)
  );

  assign cell_val = fwd_hit_r ? fwd_data_r : ram_rdata;

  bte_exec u_exec (
    .item     (exe_r),
    .cell_val (cell_val),
    .res      (exe_res),
    .wr       (exe_wr)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r        <= '0;
      mode_r      <= 1'b0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      exe_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dp_r   <= dp_nxt;
      mode_r <= mode_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= bte_pkg::dp_t'(clr_addr_r + 1'b1);
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_xfer) begin
        exe_valid_r <= 1'b1;
      end else if (exe_adv) begin
        exe_valid_r <= 1'b0;
      end
      if (exe_adv) begin
        out_valid_r <= exe_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      exe_r      <= exe_nxt;
      fwd_hit_r  <= fwd_hit_nxt;
      fwd_data_r <= exe_wr.data;
    end
    if (exe_adv && exe_valid_r) begin
      out_r <= exe_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.read_count, out_r.repeat_cnt, out_r.value, out_r.next_pc};
  assign out_tuser  = {out_r.to_cmd, out_r.kind};

  // checks
  `BTE_ASSERT_NOW(a_no_take_on_full, clk, rst_n,
    exe_valid_r && out_valid_r && !out_tready, !in_tready,
    "instruction taken while execute and output stages are both blocked")
  `BTE_ASSERT_NEXT(a_take_fills_exe, clk, rst_n,
    in_xfer, exe_valid_r,
    "taken instruction did not reach the execute stage")
  `BTE_ASSERT_NEXT(a_exe_to_out, clk, rst_n,
    exe_valid_r && exe_adv, out_valid_r,
    "executed instruction did not reach the output register")
  `BTE_ASSERT_NOW(a_clear_exclusive, clk, rst_n,
    clr_busy_r, !exe_valid_r && !in_tready,
    "instruction in flight during the tape clearing pass")

endmodule

[sv/bte_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/bte_exec.sv]
// Execute stage: result fields and cell write-back for one instruction.
module bte_exec (
  input  bte_pkg::exe_item_t   item,
  input  bte_pkg::cell_t       cell_val,
  output bte_pkg::exe_result_t res,
  output bte_pkg::tape_wr_t    wr
);

  logic cell_zero;
  logic is_io;

  assign cell_zero = (cell_val == '0);

  always_comb begin
    res            = '0;
    wr             = '0;
    res.next_pc    = 16'(bte_pkg::pc_t'(item.pc + 16'd1));
    res.kind       = bte_pkg::KIND_NONE;
    is_io          = 1'b0;
    unique case (item.op) inside
      bte_pkg::OP_ADD: begin
        wr.we   = 1'b1;
        wr.data = bte_pkg::cell_t'(cell_val + bte_pkg::cell_t'(item.operand));
      end
      bte_pkg::OP_SUB: begin
        wr.we   = 1'b1;
        wr.data = bte_pkg::cell_t'(cell_val - bte_pkg::cell_t'(item.operand));
      end
      bte_pkg::OP_JZ: begin
        if (cell_zero) begin
          res.next_pc = 16'(bte_pkg::pc_t'(item.operand));
        end
      end
      bte_pkg::OP_JNZ: begin
        if (!cell_zero) begin
          res.next_pc = 16'(bte_pkg::pc_t'(item.operand));
        end
      end
      bte_pkg::OP_CLEAR: begin
        wr.we   = 1'b1;
        wr.data = '0;
      end
      bte_pkg::OP_PUTCHAR, bte_pkg::OP_PUTNUM: begin
        is_io = 1'b1;
        if (item.op == bte_pkg::OP_PUTCHAR && item.mode && cell_zero) begin
          // command mode, empty cell: ask for the buffered command to run
          res.kind       = bte_pkg::KIND_RUN;
          res.repeat_cnt = 16'd1;
        end else begin
          if (item.op == bte_pkg::OP_PUTCHAR) begin
            res.kind = bte_pkg::KIND_CHAR;
          end else begin
            res.kind = bte_pkg::KIND_NUM;
          end
          res.value      = 8'(cell_val);
          res.repeat_cnt = item.operand;
        end
      end
      bte_pkg::OP_GETCHAR, bte_pkg::OP_GETNUM: begin
        is_io          = 1'b1;
        res.read_count = item.operand;
        wr.we          = (item.operand != 16'd0);
        wr.data        = bte_pkg::cell_t'(item.in_value);
      end
      default: begin
      end
    endcase
    res.to_cmd = is_io & item.mode;
  end

endmodule
